/* rtl/core/lru_pfc_pkg.sv */
// Package for the LRU page frame cache: sizes, operation codes and the
// command record passed from the front end to the back end. No dependencies.
package lru_pfc_pkg;
    localparam int NUM_FRAMES = 16;
    localparam int DISK_BITS  = 4;
    localparam int PAGE_BITS  = 32;
    localparam int FRAME_BITS = $clog2(NUM_FRAMES);
    localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_FLUSH   = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [DISK_BITS-1:0] disk_id;
        logic [PAGE_BITS-1:0] page_id;
    } cmd_t;
endpackage

/* rtl/core/lru_pfc_front.sv */
// Front end: takes command beats and holds them in a short queue for the
// back end. Depends on lru_pfc_pkg.
module lru_pfc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lru_pfc_pkg::cmd_t   push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output lru_pfc_pkg::cmd_t   pop_cmd
);
    lru_pfc_pkg::cmd_t mem_reg [lru_pfc_pkg::QUEUE_DEPTH];
    logic [lru_pfc_pkg::QPTR_BITS-1:0] wptr_reg, rptr_reg;
    logic [lru_pfc_pkg::QPTR_BITS:0]   cnt_reg;

    assign full      = (cnt_reg == (lru_pfc_pkg::QPTR_BITS + 1)'(lru_pfc_pkg::QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_cmd   = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* rtl/core/lru_pfc_back.sv */
// Back end: tag store, recency ranks and the lookup/update sequencer.
// Depends on lru_pfc_pkg.
module lru_pfc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  lru_pfc_pkg::cmd_t   cmd,
    output logic                cmd_pop,
    output logic                strobe,
    output logic [lru_pfc_pkg::FRAME_BITS-1:0] frame,
    output logic                hit,
    output logic                need_read,
    output logic                evict_valid,
    output logic [lru_pfc_pkg::DISK_BITS-1:0] evict_disk,
    output logic [lru_pfc_pkg::PAGE_BITS-1:0] evict_page,
    output logic                last
);
    localparam int N  = lru_pfc_pkg::NUM_FRAMES;
    localparam int FB = lru_pfc_pkg::FRAME_BITS;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_FLUSH  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    lru_pfc_pkg::cmd_t cur_reg;

    // phase bit inside ST_UPDATE: 0 = lookup, 1 = update
    logic phase_reg;

    logic [N-1:0]                       valid_reg;
    logic [lru_pfc_pkg::DISK_BITS-1:0]  disk_reg [N];
    logic [lru_pfc_pkg::PAGE_BITS-1:0]  page_reg [N];
    logic [FB-1:0]                      rank_reg [N];

    // lookup results, registered between the lookup and update phases
    logic          hit_reg, free_reg;
    logic [FB-1:0] hit_idx_reg, free_idx_reg, lru_idx_reg, hit_rank_reg;

    logic [N-1:0]  match;
    logic          any_hit, any_free;
    logic [FB-1:0] hit_idx, free_idx, lru_idx;

    always_comb
    begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = 0; i < N; i++)
        begin
            match[i] = valid_reg[i] && disk_reg[i] == cur_reg.disk_id
                       && page_reg[i] == cur_reg.page_id;
            if (match[i])
            begin
                any_hit = 1'b1;
                hit_idx = FB'(i);
            end
            // least recent has rank N-1 when the pool is full
            if (valid_reg[i] && rank_reg[i] == FB'(N - 1))
                lru_idx = FB'(i);
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = FB'(i);
            end
        end
    end

    // flush scan: lowest valid frame
    logic          scan_any;
    logic [FB-1:0] scan_idx;
    logic [N-1:0]  scan_rest;
    always_comb
    begin
        scan_any = 1'b0;
        scan_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (valid_reg[i])
            begin
                scan_any = 1'b1;
                scan_idx = FB'(i);
            end
        end
        scan_rest = valid_reg & ~(N'(1) << scan_idx);
    end

    logic [FB-1:0] tgt;
    assign tgt = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : lru_idx_reg);

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                    state_next = (cmd.operation == lru_pfc_pkg::OP_FLUSH) ? ST_FLUSH
                                                                          : ST_UPDATE;
            ST_UPDATE:
                if (phase_reg)
                    state_next = ST_IDLE;
            ST_FLUSH:
                if (scan_rest == '0) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cur_reg <= cmd;
        if (state_reg == ST_UPDATE && !phase_reg)
        begin
            hit_reg      <= any_hit;
            free_reg     <= any_free;
            hit_idx_reg  <= hit_idx;
            free_idx_reg <= free_idx;
            lru_idx_reg  <= lru_idx;
            hit_rank_reg <= rank_reg[hit_idx];
        end
        if (state_reg == ST_UPDATE && phase_reg)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (hit_reg)
                begin
                    if (valid_reg[i] && rank_reg[i] < hit_rank_reg)
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                end
                else if (valid_reg[i] && FB'(i) != tgt)
                    rank_reg[i] <= rank_reg[i] + 1'b1;
            end
            rank_reg[tgt] <= '0;
            if (!hit_reg)
            begin
                disk_reg[tgt] <= cur_reg.disk_id;
                page_reg[tgt] <= cur_reg.page_id;
            end
        end
        // result payload
        if (state_reg == ST_UPDATE && phase_reg)
        begin
            frame       <= tgt;
            hit         <= hit_reg;
            need_read   <= !hit_reg;
            evict_valid <= !hit_reg && !free_reg;
            evict_disk  <= (!hit_reg && !free_reg) ? disk_reg[tgt] : '0;
            evict_page  <= (!hit_reg && !free_reg) ? page_reg[tgt] : '0;
            last        <= 1'b1;
        end
        else if (state_reg == ST_FLUSH)
        begin
            frame       <= scan_idx;
            hit         <= 1'b0;
            need_read   <= 1'b0;
            evict_valid <= scan_any;
            evict_disk  <= scan_any ? disk_reg[scan_idx] : '0;
            evict_page  <= scan_any ? page_reg[scan_idx] : '0;
            last        <= (scan_rest == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            valid_reg <= '0;
            strobe    <= 1'b0;
        end
        else
        begin
            strobe <= (state_reg == ST_FLUSH) || (state_reg == ST_UPDATE && phase_reg);
            if (state_reg == ST_UPDATE)
                phase_reg <= !phase_reg;
            state_reg <= state_next;
            if (state_reg == ST_UPDATE && phase_reg)
                valid_reg[tgt] <= 1'b1;
            if (state_reg == ST_FLUSH)
                valid_reg <= scan_rest;
        end
    end
endmodule

/* rtl/core/lru_page_frame_cache_unit.sv */
// Top level of the LRU page frame cache: front-end queue plus back end.
// Depends on lru_pfc_pkg, lru_pfc_front and lru_pfc_back.
//
// Usage:
//   Command channel: drive operation/disk_id/page_id with start; the beat
//   is taken at a clock edge where start is high and busy is low. busy
//   rises while the two-entry command queue is full.
//   Result channel: each result beat shows for one cycle with done high;
//   the receiver cannot stall and must take it.
//   A request gives one result after acceptance (queue, lookup, update);
//   the back end takes no new request until the last one has passed the
//   lookup and rank-update steps of the back-end sequencer.
//   A flush gives one beat per occupied frame in ascending frame order, one
//   a cycle, last marked; an empty pool gives one beat with evict_valid 0.
//   Reset empties the queue and marks every frame free; no clearing pass.
module lru_page_frame_cache_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic [lru_pfc_pkg::DISK_BITS-1:0]   disk_id,
    input  logic [lru_pfc_pkg::PAGE_BITS-1:0]   page_id,
    output logic                                done,
    output logic [lru_pfc_pkg::FRAME_BITS-1:0]  frame,
    output logic                                hit,
    output logic                                need_read,
    output logic                                evict_valid,
    output logic [lru_pfc_pkg::DISK_BITS-1:0]   evict_disk,
    output logic [lru_pfc_pkg::PAGE_BITS-1:0]   evict_page,
    output logic                                last
);
    lru_pfc_pkg::cmd_t in_cmd, q_cmd;
    logic q_full, q_valid, q_pop;

    assign in_cmd = '{operation: operation, disk_id: disk_id, page_id: page_id};
    assign busy   = q_full;

    lru_pfc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !q_full),
        .push_cmd  (in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    lru_pfc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd         (q_cmd),
        .cmd_pop     (q_pop),
        .strobe      (done),
        .frame       (frame),
        .hit         (hit),
        .need_read   (need_read),
        .evict_valid (evict_valid),
        .evict_disk  (evict_disk),
        .evict_page  (evict_page),
        .last        (last)
    );
endmodule

/* rtl/core/lru_pfc_checker.sv */
// Port checker for the LRU page frame cache top level, bound in below.
// Uses nothing from lru_pfc_pkg.
module lru_pfc_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic hit,
    input logic need_read,
    input logic evict_valid,
    input logic last
);
    a_hit_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !need_read && !evict_valid && last)
        else $error("hit beat with read or evict");
    a_evict_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && need_read |-> last && !hit)
        else $error("fill beat malformed");
    a_no_done_after_reset: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result beat right after reset");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done) || !$past(start) || $past(busy))
        else $error("busy dropped without progress");
endmodule

bind lru_page_frame_cache_unit lru_pfc_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .hit         (hit),
    .need_read   (need_read),
    .evict_valid (evict_valid),
    .last        (last)
);
